/* hdl/gdow_pkg.sv */
// Shared types, constants and helper functions for the Gregorian date converter.
package gdow_pkg;

   localparam logic       CMD_DATE = 1'b0;
   localparam logic       CMD_ORD  = 1'b1;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_MONTH = 2'd1;
   localparam logic [1:0] STAT_BAD_ORD   = 2'd2;
   localparam logic [1:0] STAT_EARLY     = 2'd3;

   localparam logic [13:0] FIRST_YEAR    = 14'd1900;
   // Residues of the first walked year modulo 100 and 400.
   localparam logic [6:0]  FIRST_MOD100  = 7'd0;
   localparam logic [8:0]  FIRST_MOD400  = 9'd300;
   localparam logic [6:0]  LAST_MOD100   = 7'd99;
   localparam logic [8:0]  LAST_MOD400   = 9'd399;

   // floor(y * DIV100_RECIP / 2^DIV100_SHIFT) equals floor(y / 100) for any 14-bit y.
   localparam logic [12:0] DIV100_RECIP  = 13'd5243;
   localparam int          DIV100_SHIFT  = 19;
   localparam logic [13:0] HUNDRED       = 14'd100;

   localparam logic [8:0]  YEAR_LEN      = 9'd365;
   localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
   localparam logic [4:0]  SHORTEST_LEN  = 5'd28;

   localparam logic [3:0]  FIRST_MONTH   = 4'd1;
   localparam logic [3:0]  LAST_MONTH    = 4'd12;

   typedef struct packed {
      logic        cmd;
      logic [13:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [8:0]  ordinal_in;
   } req_type;

   typedef struct packed {
      logic [3:0] month_out;
      logic [4:0] day_out;
      logic [8:0] ordinal_out;
      logic       leap_flag;
      logic [2:0] weekday;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVQ,
      ST_LEAP,
      ST_MONTH,
      ST_YEAR,
      ST_DONE
   } state_type;

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // Sum of two residues modulo 7, both operands already below 7.
   function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
         s = s - 4'd7;
      end
      return s[2:0];
   endfunction

   // Residue of a 5-bit value modulo 7 by conditional subtraction.
   function automatic logic [2:0] mod7_5b(input logic [4:0] v);
      logic [4:0] r;
      r = v;
      if (r >= 5'd28) begin
         r = r - 5'd28;
      end
      if (r >= 5'd14) begin
         r = r - 5'd14;
      end
      if (r >= 5'd7) begin
         r = r - 5'd7;
      end
      return r[2:0];
   endfunction

endpackage

/* hdl/gregorian_date_ordinal_weekday.sv */
// Sequence: a request passes ST_DIVQ and ST_LEAP, where a bad month or ordinal goes to the result;
// an ordinal then walks the months, a date the months and then the years from 1900, one year a cycle.
// One transaction at a time: req_ready is high only while the sequencer is idle,
// from the cycle after the result is taken, so a new request waits until then.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
module gregorian_date_ordinal_weekday (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gdow_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gdow_pkg::rsp_type rsp_data
);

   gdow_pkg::state_type state_ff, state_in;
   gdow_pkg::req_type   req_ff, req_in;
   gdow_pkg::rsp_type   rsp_ff, rsp_in;
   logic [7:0]          q_ff, q_in;
   logic                leap_ff, leap_in;
   logic [3:0]          idx_ff, idx_in;
   logic [8:0]          acc_ff, acc_in;
   logic [2:0]          wd_ff, wd_in;
   logic [13:0]         yw_ff, yw_in;
   logic [6:0]          c100_ff, c100_in;
   logic [8:0]          c400_ff, c400_in;

   logic [26:0] prod;
   logic [13:0] rem100;
   logic        leap_w;
   logic [8:0]  ylen;
   logic [4:0]  len;
   logic [8:0]  len_ext;
   logic        walk_leap;

   assign req_ready = (state_ff == gdow_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == gdow_pkg::ST_DONE);
   assign rsp_data  = rsp_ff;

   always_comb begin
      prod    = 27'(req_ff.year_in) * 27'(gdow_pkg::DIV100_RECIP);
      rem100  = req_ff.year_in - (14'(q_ff) * gdow_pkg::HUNDRED);
      // Divisible by 4, and either not by 100 or also by 400 (quotient by 100 divisible by 4).
      leap_w  = (req_ff.year_in[1:0] == 2'd0) && ((rem100 != 14'd0) || (q_ff[1:0] == 2'd0));
      ylen    = leap_w ? gdow_pkg::LEAP_YEAR_LEN : gdow_pkg::YEAR_LEN;
      len     = gdow_pkg::month_len(idx_ff, leap_ff);
      len_ext = {4'd0, len};
      walk_leap = (c400_ff == 9'd0) || ((c400_ff[1:0] == 2'd0) && (c100_ff != 7'd0));

      state_in = state_ff;
      req_in   = req_ff;
      rsp_in   = rsp_ff;
      q_in     = q_ff;
      leap_in  = leap_ff;
      idx_in   = idx_ff;
      acc_in   = acc_ff;
      wd_in    = wd_ff;
      yw_in    = yw_ff;
      c100_in  = c100_ff;
      c400_in  = c400_ff;

      case (state_ff)
         gdow_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = gdow_pkg::ST_DIVQ;
            end
         end
         gdow_pkg::ST_DIVQ: begin
            q_in     = prod[26:gdow_pkg::DIV100_SHIFT];
            state_in = gdow_pkg::ST_LEAP;
         end
         gdow_pkg::ST_LEAP: begin
            leap_in = leap_w;
            idx_in  = gdow_pkg::FIRST_MONTH;
            if (req_ff.cmd == gdow_pkg::CMD_DATE) begin
               if ((req_ff.month_in < gdow_pkg::FIRST_MONTH) ||
                   (req_ff.month_in > gdow_pkg::LAST_MONTH)) begin
                  rsp_in   = '{4'd0, req_ff.day_in, 9'd0, leap_w, 3'd0,
                               gdow_pkg::STAT_BAD_MONTH};
                  state_in = gdow_pkg::ST_DONE;
               end else begin
                  acc_in   = {4'd0, req_ff.day_in};
                  wd_in    = gdow_pkg::mod7_5b(req_ff.day_in);
                  state_in = gdow_pkg::ST_MONTH;
               end
            end else begin
               if ((req_ff.ordinal_in == 9'd0) || (req_ff.ordinal_in > ylen)) begin
                  rsp_in   = '{4'd0, 5'd0, req_ff.ordinal_in, leap_w, 3'd0,
                               gdow_pkg::STAT_BAD_ORD};
                  state_in = gdow_pkg::ST_DONE;
               end else begin
                  acc_in   = req_ff.ordinal_in;
                  state_in = gdow_pkg::ST_MONTH;
               end
            end
         end
         gdow_pkg::ST_MONTH: begin
            if (req_ff.cmd == gdow_pkg::CMD_DATE) begin
               if (idx_ff < req_ff.month_in) begin
                  acc_in = acc_ff + len_ext;
                  wd_in  = gdow_pkg::add_mod7(wd_ff, 3'(len - gdow_pkg::SHORTEST_LEN));
                  idx_in = idx_ff + 4'd1;
               end else if (req_ff.year_in < gdow_pkg::FIRST_YEAR) begin
                  rsp_in   = '{req_ff.month_in, req_ff.day_in, acc_ff, leap_ff, 3'd0,
                               gdow_pkg::STAT_EARLY};
                  state_in = gdow_pkg::ST_DONE;
               end else begin
                  yw_in    = gdow_pkg::FIRST_YEAR;
                  c100_in  = gdow_pkg::FIRST_MOD100;
                  c400_in  = gdow_pkg::FIRST_MOD400;
                  state_in = gdow_pkg::ST_YEAR;
               end
            end else begin
               if (acc_ff > len_ext) begin
                  acc_in = acc_ff - len_ext;
                  idx_in = idx_ff + 4'd1;
               end else begin
                  rsp_in   = '{idx_ff, acc_ff[4:0], req_ff.ordinal_in, leap_ff, 3'd0,
                               gdow_pkg::STAT_OK};
                  state_in = gdow_pkg::ST_DONE;
               end
            end
         end
         gdow_pkg::ST_YEAR: begin
            if (yw_ff == req_ff.year_in) begin
               rsp_in   = '{req_ff.month_in, req_ff.day_in, acc_ff, leap_ff, wd_ff,
                            gdow_pkg::STAT_OK};
               state_in = gdow_pkg::ST_DONE;
            end else begin
               // A common year moves the weekday by one, a leap year by two.
               wd_in   = gdow_pkg::add_mod7(wd_ff, walk_leap ? 3'd2 : 3'd1);
               yw_in   = yw_ff + 14'd1;
               c100_in = (c100_ff == gdow_pkg::LAST_MOD100) ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == gdow_pkg::LAST_MOD400) ? 9'd0 : c400_ff + 9'd1;
            end
         end
         gdow_pkg::ST_DONE: begin
            if (rsp_ready) begin
               state_in = gdow_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gdow_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdow_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      q_ff    <= q_in;
      leap_ff <= leap_in;
      idx_ff  <= idx_in;
      acc_ff  <= acc_in;
      wd_ff   <= wd_in;
      yw_ff   <= yw_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
   end

`ifndef SYNTH
   // The sequencer never takes a new transaction while a result is pending.
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready and rsp_valid high together");

   // The month walk stays within the twelve months.
   a_month_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdow_pkg::ST_MONTH) |->
         ((idx_ff >= gdow_pkg::FIRST_MONTH) && (idx_ff <= gdow_pkg::LAST_MONTH)))
      else $error("month index out of range during walk");

   // The year walk never passes the requested year.
   a_year_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdow_pkg::ST_YEAR) |-> (yw_ff <= req_ff.year_in))
      else $error("year walk overran the requested year");

   // The walked year counters stay in step: residue mod 400 matches residue mod 100.
   a_year_mods: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gdow_pkg::ST_YEAR) |->
         ((c400_ff == 9'(c100_ff)) || (c400_ff == 9'(c100_ff) + 9'd100) ||
          (c400_ff == 9'(c100_ff) + 9'd200) || (c400_ff == 9'(c100_ff) + 9'd300)))
      else $error("year residue counters out of step");

   // A result for a bad month or ordinal carries no month, and the weekday is below seven.
   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.weekday < 3'd7) &&
         ((rsp_data.status == gdow_pkg::STAT_OK) || (rsp_data.status == gdow_pkg::STAT_EARLY) ||
          (rsp_data.month_out == 4'd0))))
      else $error("malformed result");
`endif

endmodule
